// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the linear convolution RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent holds -> consequent holds in the same cycle.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent holds -> consequent holds in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Condition holds at every clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
        else $error(msg);

`endif

// File: hw/rtl/lconv_pkg.sv
// Types and constants shared by the linear convolution block.
// No dependencies; imported by the controller, the datapath and the top level.
`default_nettype none

package lconv_pkg;

    localparam int SAMPLE_W = 16;
    localparam int PROD_W   = 32;
    localparam int TERM_W   = 37;
    localparam int POS_W    = 6;

    // Sequence select carried by the mode field
    localparam logic MODE_FIRST  = 1'b0;
    localparam logic MODE_SECOND = 1'b1;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [PROD_W-1:0]   t_prod;
    typedef logic signed [TERM_W-1:0]   t_term;
    typedef logic [POS_W-1:0]           t_pos;

    // Controller to datapath commands
    typedef struct packed {
        logic load;        // input transfer: store element
        logic issue;       // product pair addressed this cycle
        logic term_first;  // first product of a term
        logic term_last;   // last product of a term
        logic run_last;    // last product of the run
        t_pos pos;         // term index
        logic clear;       // end of run: reset counts and drop flag
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic run_done;    // final term is on the outputs
    } t_dp_stat;

endpackage

`default_nettype wire

// File: hw/rtl/lconv_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used for both sample stores.
`default_nettype none

module lconv_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: hw/rtl/lconv_ctrl.sv
// Run controller: accepts transfers and sequences the product pairs of each term.
// Depends on lconv_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module lconv_ctrl import lconv_pkg::*; #(
    parameter int MAX_LEN = 32,
    localparam int AW     = $clog2(MAX_LEN),
    localparam int CW     = $clog2(MAX_LEN + 1)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic          i_mode,
    input  wire logic          i_final_req,
    output logic               o_busy,
    input  wire logic [CW-1:0] i_na,
    input  wire logic [CW-1:0] i_nb,
    input  wire t_dp_stat      i_stat,
    output t_dp_cmd            o_cmd,
    output logic      [AW-1:0] o_addr_a,
    output logic      [AW-1:0] o_addr_b
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_RUN   = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;

    logic [1:0]    r_state, n_state;
    t_pos          r_k, n_k;
    logic [AW-1:0] r_i, n_i;
    logic [AW-1:0] r_hi, n_hi;
    logic          r_first, n_first;

    logic          accept;
    logic          run_start;
    t_pos          na_w, nb_w, last_k, k_next;
    logic [AW-1:0] lo_next, hi_next;
    logic          term_end, run_end;

    assign accept    = i_start && (r_state == S_IDLE);
    assign run_start = accept && (i_mode == MODE_SECOND) && i_final_req;

    // bounds of the first-sequence index for the next term
    assign na_w    = POS_W'(i_na);
    assign nb_w    = POS_W'(i_nb);
    assign last_k  = na_w + nb_w - POS_W'(2);
    assign k_next  = r_k + POS_W'(1);
    assign lo_next = (k_next >= nb_w) ? AW'(k_next - nb_w + POS_W'(1)) : '0;
    assign hi_next = (k_next < na_w) ? AW'(k_next) : AW'(na_w - POS_W'(1));

    assign term_end = (r_i == r_hi);
    assign run_end  = term_end && (r_k == last_k);

    // next-state logic
    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        n_i     = r_i;
        n_hi    = r_hi;
        n_first = r_first;
        unique case (r_state)
            S_IDLE: begin
                if (run_start) begin
                    n_state = S_RUN;
                    n_k     = '0;
                    n_i     = '0;
                    n_hi    = '0;
                    n_first = 1'b1;
                end
            end
            S_RUN: begin
                if (term_end) begin
                    if (run_end) begin
                        n_state = S_DRAIN;
                        n_first = 1'b0;
                    end else begin
                        n_k     = k_next;
                        n_i     = lo_next;
                        n_hi    = hi_next;
                        n_first = 1'b1;
                    end
                end else begin
                    n_i     = r_i + AW'(1);
                    n_first = 1'b0;
                end
            end
            S_DRAIN: begin
                if (i_stat.run_done) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= '0;
            r_i     <= '0;
            r_hi    <= '0;
            r_first <= 1'b0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_i     <= n_i;
            r_hi    <= n_hi;
            r_first <= n_first;
        end
    end

    // commands and store addresses
    always_comb begin
        o_cmd.load       = accept;
        o_cmd.issue      = (r_state == S_RUN);
        o_cmd.term_first = r_first;
        o_cmd.term_last  = term_end;
        o_cmd.run_last   = run_end;
        o_cmd.pos        = r_k;
        o_cmd.clear      = (r_state == S_DRAIN) && i_stat.run_done;
    end

    assign o_addr_a = r_i;
    assign o_addr_b = AW'(r_k - POS_W'(r_i));
    assign o_busy   = (r_state != S_IDLE);

    `ASSERT_IMPLY(a_i_in_range, i_clk, i_rst_n, r_state == S_RUN, r_i <= r_hi,
        "first-sequence index passed the term bound")
    `ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, run_start, o_busy && r_first,
        "run start did not enter the run with a fresh term")
    `ASSERT_IMPLY(a_first_only_run, i_clk, i_rst_n, r_first, r_state == S_RUN,
        "term start flagged outside a run")

endmodule

`default_nettype wire

// File: hw/rtl/lconv_dp.sv
// Datapath: sample stores, element counts, shared multiply-accumulate and result registers.
// Depends on lconv_pkg, lconv_ram and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module lconv_dp import lconv_pkg::*; #(
    parameter int MAX_LEN = 32,
    localparam int AW     = $clog2(MAX_LEN),
    localparam int CW     = $clog2(MAX_LEN + 1)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire t_dp_cmd       i_cmd,
    input  wire logic          i_mode,
    input  wire t_sample       i_sample,
    input  wire logic [AW-1:0] i_addr_a,
    input  wire logic [AW-1:0] i_addr_b,
    output t_dp_stat           o_stat,
    output logic      [CW-1:0] o_na,
    output logic      [CW-1:0] o_nb,
    output logic               o_strobe,
    output t_term              o_term,
    output t_pos               o_position,
    output logic               o_end_of_run,
    output logic               o_dropped
);

    logic [CW-1:0] r_cnt_a, r_cnt_b;
    logic          r_ovf;
    logic          full_a, full_b, wr_a, wr_b, drop;
    logic          first_empty;
    t_sample       rd_a, rd_b, mul_a, mul_b;

    // pipeline tags
    logic          r_s1_vld, r_s1_first, r_s1_last, r_s1_end;
    t_pos          r_s1_pos;
    logic          r_s2_vld, r_s2_first, r_s2_last, r_s2_end;
    t_pos          r_s2_pos;
    t_prod         r_prod;

    // result registers
    t_term         r_acc, acc_sum;
    logic          r_strobe, r_end, r_drop;
    t_pos          r_pos;

    // element loading
    assign full_a = (r_cnt_a >= CW'(MAX_LEN));
    assign full_b = (r_cnt_b >= CW'(MAX_LEN));
    assign wr_a   = i_cmd.load && (i_mode == MODE_FIRST) && !full_a;
    assign wr_b   = i_cmd.load && (i_mode == MODE_SECOND) && !full_b;
    assign drop   = i_cmd.load && (((i_mode == MODE_FIRST) && full_a)
                                || ((i_mode == MODE_SECOND) && full_b));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_a <= '0;
            r_cnt_b <= '0;
            r_ovf   <= 1'b0;
        end else if (i_cmd.clear) begin
            r_cnt_a <= '0;
            r_cnt_b <= '0;
            r_ovf   <= 1'b0;
        end else begin
            if (wr_a) begin
                r_cnt_a <= r_cnt_a + CW'(1);
            end
            if (wr_b) begin
                r_cnt_b <= r_cnt_b + CW'(1);
            end
            if (drop) begin
                r_ovf <= 1'b1;
            end
        end
    end

    lconv_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_LEN)) u_store_a (
        .i_clk  (i_clk),
        .i_we   (wr_a),
        .i_waddr(r_cnt_a[AW-1:0]),
        .i_wdata(i_sample),
        .i_raddr(i_addr_a),
        .o_rdata(rd_a)
    );

    lconv_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_LEN)) u_store_b (
        .i_clk  (i_clk),
        .i_we   (wr_b),
        .i_waddr(r_cnt_b[AW-1:0]),
        .i_wdata(i_sample),
        .i_raddr(i_addr_b),
        .o_rdata(rd_b)
    );

    // an empty first sequence runs as a single zero element
    assign first_empty = (r_cnt_a == '0);
    assign o_na        = first_empty ? CW'(1) : r_cnt_a;
    assign o_nb        = r_cnt_b;
    assign mul_a       = first_empty ? '0 : rd_a;
    assign mul_b       = rd_b;

    // pipeline valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_s1_vld <= i_cmd.issue;
            r_s2_vld <= r_s1_vld;
            r_strobe <= r_s2_vld && r_s2_last;
        end
    end

    // tags, product and accumulator
    assign acc_sum = r_s2_first ? TERM_W'(r_prod) : r_acc + TERM_W'(r_prod);

    always_ff @(posedge i_clk) begin
        r_s1_first <= i_cmd.term_first;
        r_s1_last  <= i_cmd.term_last;
        r_s1_end   <= i_cmd.run_last;
        r_s1_pos   <= i_cmd.pos;

        r_s2_first <= r_s1_first;
        r_s2_last  <= r_s1_last;
        r_s2_end   <= r_s1_end;
        r_s2_pos   <= r_s1_pos;
        r_prod     <= PROD_W'(mul_a) * PROD_W'(mul_b);

        if (r_s2_vld) begin
            r_acc <= acc_sum;
        end
        r_end  <= r_s2_end;
        r_pos  <= r_s2_pos;
        r_drop <= r_ovf;
    end

    assign o_strobe      = r_strobe;
    assign o_term        = r_acc;
    assign o_position    = r_pos;
    assign o_end_of_run  = r_end;
    assign o_dropped     = r_drop;
    assign o_stat.run_done = r_strobe && r_end;

    `ASSERT_NEXT(a_quiet_after_run, i_clk, i_rst_n, o_strobe && o_end_of_run, !o_strobe,
        "result after the final term of a run")
    `ASSERT_IMPLY(a_load_pipe_empty, i_clk, i_rst_n, i_cmd.load,
        !r_s1_vld && !r_s2_vld && !r_strobe, "transfer taken while a run is in flight")
    `ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n,
        (r_cnt_a <= CW'(MAX_LEN)) && (r_cnt_b <= CW'(MAX_LEN)),
        "element count beyond store depth")

endmodule

`default_nettype wire

// File: hw/rtl/linear_convolution_top.sv
// Top level of the linear convolution block: controller plus datapath.
// Depends on lconv_pkg, lconv_ctrl, lconv_dp and lconv_ram.
`default_nettype none

// Loading: a transfer is taken whenever start is high and busy is low, and an
// element beyond MAX_LEN in its sequence is discarded and reported through
// dropped. The last element of the second sequence starts a run: busy stays
// high while every product pair goes through the single shared multiply-
// accumulate once, one pair per cycle (na counts an empty first sequence as
// one), and while the three-stage read/multiply/accumulate pipeline drains.
// The na+nb-1 terms come out in index order, each on the result ports for
// exactly one cycle while o_strobe is high; the receiver cannot stall them
// and must take each one. After the final term, both sequences and the drop
// flag are cleared.

module linear_convolution_top import lconv_pkg::*; #(
    parameter int MAX_LEN = 32
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_start,
    output logic      o_busy,
    input  wire logic i_mode,
    input  wire t_sample i_sample,
    input  wire logic i_final_req,
    output logic      o_strobe,
    output t_term     o_term,
    output t_pos      o_position,
    output logic      o_end_of_run,
    output logic      o_dropped
);

    localparam int AW = $clog2(MAX_LEN);
    localparam int CW = $clog2(MAX_LEN + 1);

    t_dp_cmd       cmd;
    t_dp_stat      stat;
    logic [CW-1:0] na, nb;
    logic [AW-1:0] addr_a, addr_b;

    lconv_ctrl #(.MAX_LEN(MAX_LEN)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .i_mode     (i_mode),
        .i_final_req(i_final_req),
        .o_busy     (o_busy),
        .i_na       (na),
        .i_nb       (nb),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_addr_a   (addr_a),
        .o_addr_b   (addr_b)
    );

    lconv_dp #(.MAX_LEN(MAX_LEN)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_mode      (i_mode),
        .i_sample    (i_sample),
        .i_addr_a    (addr_a),
        .i_addr_b    (addr_b),
        .o_stat      (stat),
        .o_na        (na),
        .o_nb        (nb),
        .o_strobe    (o_strobe),
        .o_term      (o_term),
        .o_position  (o_position),
        .o_end_of_run(o_end_of_run),
        .o_dropped   (o_dropped)
    );

endmodule

`default_nettype wire

// File: verif/tb_linear_convolution_top.sv
// Self-checking testbench for linear_convolution_top: loads pairs of sample
// sequences, predicts every convolution term and checks each strobed result.
// Depends on lconv_pkg and linear_convolution_top.
`timescale 1ns / 100ps

module tb_linear_convolution_top;
    import lconv_pkg::*;

    localparam int      STORE_DEPTH  = 32;
    localparam int      RANDOM_ITEMS = 210;
    localparam t_sample SAMPLE_MIN   = 16'sh8000;
    localparam t_sample SAMPLE_MAX   = 16'sh7FFF;

    // One predicted output term
    typedef struct {
        t_term term;
        t_pos  pos;
        logic  last;
        logic  drop;
    } t_conv_term;

    // Scoreboard: mirrors both sequence stores and queues the predicted terms
    class t_conv_scoreboard;
        t_sample    first_seq[$];
        t_sample    second_seq[$];
        bit         drop_seen;
        t_conv_term pending_terms[$];
        int         err_count;

        function new();
            drop_seen = 1'b0;
            err_count = 0;
        endfunction

        function int pending();
            return pending_terms.size();
        endfunction

        // Note an accepted input transfer; the last second-sequence element
        // produces the whole run of terms
        function void take_element(logic mode, t_sample smp, logic fin);
            t_sample    a_seq[$];
            int         na;
            int         nb;
            longint     acc;
            t_conv_term t;
            if (mode == MODE_FIRST) begin
                if (first_seq.size() < STORE_DEPTH) first_seq.push_back(smp);
                else drop_seen = 1'b1;
                return;
            end
            if (second_seq.size() < STORE_DEPTH) second_seq.push_back(smp);
            else drop_seen = 1'b1;
            if (!fin) return;

            // empty first sequence acts as a single zero
            a_seq = first_seq;
            if (a_seq.size() == 0) a_seq.push_back('0);
            na = a_seq.size();
            nb = second_seq.size();
            for (int k = 0; k < na + nb - 1; k++) begin
                acc = 0;
                for (int i = 0; i < na; i++) begin
                    if (k >= i && k - i < nb)
                        acc += longint'(a_seq[i]) * longint'(second_seq[k - i]);
                end
                t.term = t_term'(acc);
                t.pos  = t_pos'(k);
                t.last = (k == na + nb - 2);
                t.drop = drop_seen;
                pending_terms.push_back(t);
            end
            first_seq.delete();
            second_seq.delete();
            drop_seen = 1'b0;
        endfunction

        // Compare one strobed result with the oldest prediction
        function void check_term(t_term term, t_pos pos, logic last, logic drop);
            t_conv_term want;
            if (pending_terms.size() == 0) begin
                $error("unexpected term at position %0d", pos);
                err_count++;
                return;
            end
            want = pending_terms.pop_front();
            if (term !== want.term) begin
                $error("term: expected %0d, got %0d", want.term, term);
                err_count++;
            end
            if (pos !== want.pos) begin
                $error("position: expected %0d, got %0d", want.pos, pos);
                err_count++;
            end
            if (last !== want.last) begin
                $error("end_of_run: expected %0b, got %0b", want.last, last);
                err_count++;
            end
            if (drop !== want.drop) begin
                $error("dropped: expected %0b, got %0b", want.drop, drop);
                err_count++;
            end
        endfunction
    endclass

    logic    i_clk       = 1'b0;
    logic    i_rst_n     = 1'b0;
    logic    i_start     = 1'b0;
    logic    i_mode      = 1'b0;
    t_sample i_sample    = '0;
    logic    i_final_req = 1'b0;
    logic    o_busy;
    logic    o_strobe;
    t_term   o_term;
    t_pos    o_position;
    logic    o_end_of_run;
    logic    o_dropped;

    t_conv_scoreboard sb = new();

    linear_convolution_top #(
        .MAX_LEN(STORE_DEPTH)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_mode      (i_mode),
        .i_sample    (i_sample),
        .i_final_req (i_final_req),
        .o_strobe    (o_strobe),
        .o_term      (o_term),
        .o_position  (o_position),
        .o_end_of_run(o_end_of_run),
        .o_dropped   (o_dropped)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Monitor: input transfers feed the predictor, strobes are checked
    always @(posedge i_clk) begin
        if (i_rst_n && i_start && !o_busy) sb.take_element(i_mode, i_sample, i_final_req);
        if (i_rst_n && o_strobe) sb.check_term(o_term, o_position, o_end_of_run, o_dropped);
    end

    // Present one element and hold it until the block takes the transfer
    task automatic send_element(input logic mode, input t_sample smp, input logic fin);
        i_start     <= 1'b1;
        i_mode      <= mode;
        i_sample    <= smp;
        i_final_req <= fin;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
    endtask

    // Sender idle for the gap given by n, with junk on the payload ports
    task automatic pause_sender(input int n);
        if (n > 0) begin
            i_start     <= 1'b0;
            i_mode      <= $urandom_range(0, 1);
            i_sample    <= t_sample'($urandom);
            i_final_req <= $urandom_range(0, 1);
            repeat (n) @(posedge i_clk);
        end
    endtask

    // Hold off until every predicted term has come out
    task automatic wait_drained();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Mostly back-to-back or short gaps, occasionally a long one
    function automatic int pick_gap(bit calm);
        int r;
        r = $urandom_range(0, 9);
        if (calm || r < 5) return 0;
        if (r < 9) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic t_sample pick_sample(bit fill_min);
        int r;
        r = $urandom_range(0, 7);
        if (fill_min || r == 0) return SAMPLE_MIN;
        if (r == 1) return SAMPLE_MAX;
        if (r == 2) return '0;
        return t_sample'($urandom);
    endfunction

    // One job: na first and nb second elements in random interleaving,
    // closed by the final second element; returns the item count
    task automatic run_job(output int n_items);
        int na;
        int nb;
        int left_a;
        int left_b;
        int r;
        bit calm;
        bit fill_min;
        r = $urandom_range(0, 19);
        na = (r == 0) ? $urandom_range(30, 34) : (r == 1) ? 0 : $urandom_range(1, 6);
        r = $urandom_range(0, 19);
        nb = (r == 0) ? $urandom_range(30, 34) : $urandom_range(1, 6);
        fill_min = ($urandom_range(0, 15) == 0);
        calm     = ($urandom_range(0, 3) == 0);
        left_a = na;
        left_b = nb - 1;
        while (left_a + left_b > 0) begin
            if (left_a > 0 && (left_b == 0 || $urandom_range(0, 1) == 1)) begin
                send_element(MODE_FIRST, pick_sample(fill_min), $urandom_range(0, 5) == 0);
                left_a--;
            end else begin
                send_element(MODE_SECOND, pick_sample(fill_min), 1'b0);
                left_b--;
            end
            pause_sender(pick_gap(calm));
        end
        send_element(MODE_SECOND, pick_sample(fill_min), 1'b1);
        pause_sender(pick_gap(calm));
        n_items = na + nb;
    endtask

    // Stimulus
    initial begin
        int sent;
        int n;
        int spin;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty first sequence: one all-zero term
        send_element(MODE_SECOND, SAMPLE_MAX, 1'b1);
        // final flag on the first sequence does not close it; extreme products
        send_element(MODE_FIRST, SAMPLE_MIN, 1'b1);
        send_element(MODE_FIRST, SAMPLE_MIN, 1'b0);
        send_element(MODE_SECOND, SAMPLE_MIN, 1'b0);
        send_element(MODE_SECOND, SAMPLE_MAX, 1'b1);
        wait_drained();
        // interleaved sequences with small and large values
        send_element(MODE_SECOND, -16'sd1, 1'b0);
        send_element(MODE_FIRST, 16'sd1, 1'b0);
        pause_sender(3);
        send_element(MODE_SECOND, '0, 1'b0);
        send_element(MODE_FIRST, SAMPLE_MAX, 1'b0);
        send_element(MODE_SECOND, 16'sd12345, 1'b1);
        // single element each
        send_element(MODE_FIRST, 16'sd5, 1'b0);
        send_element(MODE_SECOND, -16'sd7, 1'b1);
        wait_drained();

        // random jobs
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            run_job(n);
            sent += n;
            if ($urandom_range(0, 5) == 0) wait_drained();
        end

        // wind down
        i_start <= 1'b0;
        spin = 0;
        @(posedge i_clk);
        while (sb.pending() != 0 && spin < 5000) begin
            @(posedge i_clk);
            spin++;
        end
        repeat (10) @(posedge i_clk);
        if (sb.pending() != 0) begin
            $error("%0d predicted terms never came out", sb.pending());
            sb.err_count++;
        end
        if (sb.err_count == 0) begin
            $display("tb_linear_convolution_top: done, clean");
        end else begin
            $display("tb_linear_convolution_top: done, errors");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2000000;
        $display("tb_linear_convolution_top: done, errors");
        $finish;
    end

endmodule
